FILE: design/systematic_resampler_top_assert.svh
// Assertion macros for the systematic resampler top level.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH
`define SYSTEMATIC_RESAMPLER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SRES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SRES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sres_pkg.sv
// Shared constants, microcode types and control/status structs for the
// systematic resampler. No dependencies.
package sres_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int WEIGHT_W      = 16;
  localparam int SUM_W         = 23;
  localparam int QUO_W         = 17;
  localparam int DIV_BITS_W    = 5;
  localparam int STEP_W        = 3;

  localparam logic [QUO_W-1:0]      ONE_FIX   = 17'h10000;
  localparam logic [DIV_BITS_W-1:0] DIV_STEPS = 5'd17;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_DIV_INIT = 3'd2,
    OP_DIV_STEP = 3'd3,
    OP_CMP      = 3'd4,
    OP_EMIT     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_ACC_LAST = 3'd1,
    COND_DIV_MORE = 3'd2,
    COND_ADVANCE  = 3'd3,
    COND_RUN_DONE = 3'd4
  } cond_t;

  typedef enum logic [STEP_W-1:0] {
    S_IDLE     = 3'd0,
    S_DIV_INIT = 3'd1,
    S_DIV_STEP = 3'd2,
    S_READ     = 3'd3,
    S_CMP      = 3'd4,
    S_EMIT     = 3'd5
  } step_t;

  typedef struct packed {
    logic ready;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic acc_last;
    logic div_more;
    logic advance;
    logic stall;
    logic run_done;
  } status_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jump_to;
    step_t else_to;
  } ucode_t;

endpackage

FILE: design/sres_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sres_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/sres_seq.sv
// Microcode sequencer: program table, step counter and conditional jumps.
// Depends on sres_pkg.
module sres_seq import sres_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t uword;
  logic   cond_met;

  function automatic ucode_t program_rom(input step_t s);
    ucode_t w;
    w = '{ctrl: '{ready: 1'b0, op: OP_NOP}, cond: COND_ALWAYS,
           jump_to: S_IDLE, else_to: S_IDLE};
    case (s)
      S_IDLE: begin
        w = '{ctrl: '{ready: 1'b1, op: OP_LOAD}, cond: COND_ACC_LAST,
              jump_to: S_DIV_INIT, else_to: S_IDLE};
      end
      S_DIV_INIT: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_DIV_INIT}, cond: COND_ALWAYS,
              jump_to: S_DIV_STEP, else_to: S_DIV_STEP};
      end
      S_DIV_STEP: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_DIV_STEP}, cond: COND_DIV_MORE,
              jump_to: S_DIV_STEP, else_to: S_READ};
      end
      S_READ: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_NOP}, cond: COND_ALWAYS,
              jump_to: S_CMP, else_to: S_CMP};
      end
      S_CMP: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_CMP}, cond: COND_ADVANCE,
              jump_to: S_READ, else_to: S_EMIT};
      end
      S_EMIT: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_EMIT}, cond: COND_RUN_DONE,
              jump_to: S_IDLE, else_to: S_CMP};
      end
      default: begin
        w = '{ctrl: '{ready: 1'b0, op: OP_NOP}, cond: COND_ALWAYS,
              jump_to: S_IDLE, else_to: S_IDLE};
      end
    endcase
    return w;
  endfunction

  assign uword = program_rom(step);
  assign ctrl  = uword.ctrl;

  always_comb begin
    case (uword.cond)
      COND_ALWAYS:   cond_met = 1'b1;
      COND_ACC_LAST: cond_met = status.acc_last;
      COND_DIV_MORE: cond_met = status.div_more;
      COND_ADVANCE:  cond_met = status.advance;
      COND_RUN_DONE: cond_met = status.run_done;
      default:       cond_met = 1'b1;
    endcase
  end

  always_comb begin
    if (status.stall) begin
      step_next = step;
    end else if (cond_met) begin
      step_next = uword.jump_to;
    end else begin
      step_next = uword.else_to;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: design/sres_dp.sv
// Resampler datapath: prefix-sum load, bit-serial reciprocal divider,
// threshold walk over the prefix-sum RAM and the output register.
// Depends on sres_pkg and sres_ram.
module sres_dp import sres_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  output status_t             status,
  input  logic                in_valid,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [WEIGHT_W-1:0] offset,
  input  logic                last_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    parent_index,
  output logic [QUO_W-1:0]    weight_out,
  output logic                last_result
);

  logic [CNT_W-1:0]      count;
  logic [SUM_W-1:0]      prev;
  logic [WEIGHT_W-1:0]   off_reg;
  logic [QUO_W-1:0]      dvd;
  logic [QUO_W-1:0]      quo;
  logic [CNT_W-1:0]      rem;
  logic [DIV_BITS_W-1:0] bits;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      j;
  logic [CNT_W-1:0]      frac;
  logic [QUO_W-1:0]      thr;

  logic                  accept;
  logic                  wr_en;
  logic [SUM_W-1:0]      sum_next;
  logic [SUM_W-1:0]      rdata;
  logic [CNT_W:0]        trial;
  logic                  div_ge;
  logic [CNT_W:0]        frac_sum;
  logic                  frac_wrap;
  logic [QUO_W-1:0]      thr_next;
  logic [CNT_W-1:0]      last_pos;
  logic                  slot_free;
  logic                  push;

  assign accept   = in_valid & ctrl.ready;
  assign wr_en    = accept && !count[CNT_W-1];
  assign sum_next = ((count == '0) ? '0 : prev) + {{(SUM_W-WEIGHT_W){1'b0}}, weight};

  sres_ram #(.WIDTH(SUM_W), .DEPTH(TABLE_DEPTH)) u_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (sum_next),
    .rd_addr (idx),
    .rd_data (rdata)
  );

  always_comb begin
    trial     = {rem, dvd[QUO_W-1]};
    div_ge    = trial >= {1'b0, count};
    frac_sum  = {1'b0, frac} + {1'b0, rem};
    frac_wrap = frac_sum >= {1'b0, count};
    // threshold j+1 = threshold j + floor(ONE/n), plus one when the remainder wraps
    thr_next  = thr + quo + {{(QUO_W-1){1'b0}}, frac_wrap};
    last_pos  = count - 7'd1;
    slot_free = !out_valid || out_ready;
    push      = (ctrl.op == OP_EMIT) && slot_free;

    status.acc_last = accept & last_weight;
    status.div_more = bits != 5'd1;
    status.advance  = (ctrl.op == OP_CMP) && ({1'b0, idx} != last_pos)
                      && ({{(SUM_W-QUO_W){1'b0}}, thr} > rdata);
    status.stall    = (ctrl.op == OP_EMIT) && !slot_free;
    status.run_done = {1'b0, j} == last_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        count <= count + 7'd1;
      end else if (push && status.run_done) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (wr_en) begin
          prev <= sum_next;
        end
        if (accept) begin
          off_reg <= offset;
        end
      end
      OP_DIV_INIT: begin
        dvd  <= ONE_FIX;
        quo  <= '0;
        rem  <= '0;
        bits <= DIV_STEPS;
        idx  <= '0;
        j    <= '0;
        frac <= '0;
        thr  <= {{(QUO_W-WEIGHT_W){1'b0}}, off_reg};
      end
      OP_DIV_STEP: begin
        // restoring division of ONE by n, one quotient bit per step
        if (div_ge) begin
          rem <= CNT_W'(trial - {1'b0, count});
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        quo  <= {quo[QUO_W-2:0], div_ge};
        dvd  <= {dvd[QUO_W-2:0], 1'b0};
        bits <= bits - 5'd1;
      end
      OP_CMP: begin
        if (status.advance) begin
          idx <= idx + 6'd1;
        end
      end
      OP_EMIT: begin
        if (push) begin
          parent_index <= idx;
          weight_out   <= quo;
          last_result  <= status.run_done;
          if (!status.run_done) begin
            j    <= j + 6'd1;
            thr  <= thr_next;
            frac <= frac_wrap ? CNT_W'(frac_sum - {1'b0, count}) : frac_sum[CNT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/systematic_resampler_top.sv
// Systematic resampler, top level. Weights load back to back while idle.
// After the last weight: reciprocal division (init step, a step per quotient
// bit) and one RAM read. Each result takes a compare and an emit step, plus
// a read and a compare per skipped particle; output back-pressure stalls the
// emit step. New weights are taken only between runs. Synchronous active-high
// reset returns to the idle step with an empty table and no pending result.
module systematic_resampler_top import sres_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [WEIGHT_W-1:0] offset,
  input  logic                last_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    parent_index,
  output logic [QUO_W-1:0]    weight_out,
  output logic                last_result
);

  ctrl_t   ctrl;
  status_t status;
  logic    last_taken;
  logic    final_push;

  sres_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  sres_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .in_valid     (in_valid),
    .weight       (weight),
    .offset       (offset),
    .last_weight  (last_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parent_index (parent_index),
    .weight_out   (weight_out),
    .last_result  (last_result)
  );

  assign in_ready   = ctrl.ready;
  assign last_taken = in_valid && in_ready && last_weight;
  assign final_push = (ctrl.op == OP_EMIT) && !status.stall && status.run_done;

`include "systematic_resampler_top_assert.svh"

  `SRES_ASSERT_SAME(a_idle_no_stall, in_ready, !status.stall, "stall seen while idle")
  `SRES_ASSERT_NEXT(a_run_starts, last_taken, !in_ready, "run did not start after last weight")
  `SRES_ASSERT_NEXT(a_run_ends, final_push, in_ready && out_valid && last_result, "run did not end")

endmodule

FILE: bench/resampler_checker.sv
// Watches both channels of the systematic resampler, predicts each selected index
// from the accepted weights and compares the results in order.
// Depends on sres_pkg for field widths and the table depth.
module resampler_checker import sres_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [WEIGHT_W-1:0] offset,
  input  logic                last_weight,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [IDX_W-1:0]    parent_index,
  input  logic [QUO_W-1:0]    weight_out,
  input  logic                last_result,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [IDX_W-1:0] parent;
    logic [QUO_W-1:0] share;
    logic             final_pick;
  } pick_t;

  pick_t            picks_due[$];
  logic [SUM_W-1:0] cum_weight [TABLE_DEPTH];
  int unsigned      fill;

  initial begin
    fail_count = 0;
    pending    = 0;
    fill       = 0;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Store one weight; on the last weight of a set, walk the thresholds.
  task automatic absorb_weight(input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] off,
                               input logic fin);
    int unsigned     n;
    int unsigned     idx;
    longint unsigned thr;
    logic [QUO_W-1:0] share;
    pick_t           p;
    if (fill < TABLE_DEPTH) begin
      cum_weight[fill] = ((fill == 0) ? '0 : cum_weight[fill-1]) + SUM_W'(w);
      fill++;
    end
    if (fin) begin
      n     = fill;
      share = QUO_W'(ONE_FIX / n);
      idx   = 0;
      for (int j = 0; j < n; j++) begin
        thr = longint'(off) + (longint'(j) * longint'(ONE_FIX)) / n;
        // advance past every particle but the last whose running sum is below the threshold
        while (idx < n - 1 && thr > longint'(cum_weight[idx]))
          idx++;
        p.parent     = IDX_W'(idx);
        p.share      = share;
        p.final_pick = (j == n - 1);
        picks_due.push_back(p);
      end
      fill = 0;
    end
  endtask

  always @(posedge clk) begin
    pick_t exp_pick;
    if (rst) begin
      fill = 0;
      picks_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (picks_due.size() == 0) begin
          report($sformatf("result with nothing pending: parent_index %0d", parent_index));
        end else begin
          exp_pick = picks_due.pop_front();
          if (parent_index !== exp_pick.parent)
            report($sformatf("parent_index %0d, predicted %0d", parent_index, exp_pick.parent));
          if (weight_out !== exp_pick.share)
            report($sformatf("weight_out %0d, predicted %0d", weight_out, exp_pick.share));
          if (last_result !== exp_pick.final_pick)
            report($sformatf("last_result %0b, predicted %0b", last_result,
                             exp_pick.final_pick));
        end
      end
      if (in_valid && in_ready)
        absorb_weight(weight, offset, last_weight);
    end
    pending = picks_due.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the systematic resampler testbench: clock, reset, weight-set stimulus
// with bursty sending and a stalling receiver, and the final verdict.
// Depends on sres_pkg, systematic_resampler_top and resampler_checker.
module tb;
  import sres_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [WEIGHT_W-1:0] weight = '0;
  logic [WEIGHT_W-1:0] offset = '0;
  logic                last_weight = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IDX_W-1:0]    parent_index;
  logic [QUO_W-1:0]    weight_out;
  logic                last_result;
  int                  fail_count;
  int                  pending;

  int unsigned sent_count = 0;
  int unsigned burst_left = 0;

  always #1 clk = ~clk;

  systematic_resampler_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .weight       (weight),
    .offset       (offset),
    .last_weight  (last_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parent_index (parent_index),
    .weight_out   (weight_out),
    .last_result  (last_result)
  );

  resampler_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .weight       (weight),
    .offset       (offset),
    .last_weight  (last_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parent_index (parent_index),
    .weight_out   (weight_out),
    .last_result  (last_result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Receiver: switch at random between stall patterns.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_phase % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] off,
                           input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    weight      <= w;
    offset      <= off;
    last_weight <= fin;
    // ready only moves at rising edges, so the falling edge shows the coming edge
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent_count++;
  endtask

  // One set of n weights; extra weights past the table depth are dropped.
  task automatic send_set(input int unsigned n, input bit noisy, input bit wild_off);
    int unsigned         raw [80];
    int unsigned         total;
    int unsigned         eff;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] off;
    longint unsigned     scaled;
    total = 0;
    for (int i = 0; i < n; i++) begin
      raw[i] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1000);
      total += raw[i];
    end
    if (total == 0) begin
      raw[0] = 1;
      total  = 1;
    end
    eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    off = wild_off ? WEIGHT_W'($urandom) : WEIGHT_W'($urandom_range(0, 65536 / eff - 1));
    for (int i = 0; i < n; i++) begin
      scaled = (longint'(raw[i]) * 65536) / total;
      w = noisy ? WEIGHT_W'($urandom) : ((scaled > 65535) ? 16'hFFFF : WEIGHT_W'(scaled));
      send_item(w, (i == n - 1) ? off : WEIGHT_W'($urandom), i == n - 1);
    end
  endtask

  initial begin
    int unsigned kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single particle, full weight and the widest uniform weight
    send_item(16'hFFFF, 16'h0000, 1'b1);
    // single particle, zero weight, largest offset
    send_item(16'h0000, 16'hFFFF, 1'b1);
    // two particles, empty first, threshold runs to the second
    send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'h7FFF, 1'b1);
    // equal weights
    repeat (3) send_item(16'h4000, 16'hAAAA, 1'b0);
    send_item(16'h4000, 16'h0000, 1'b1);
    // all-zero weights: walk saturates at the last particle
    send_item(16'h0000, 16'h5555, 1'b0);
    send_item(16'h0000, 16'h0000, 1'b0);
    send_item(16'h0000, 16'h1234, 1'b1);
    // all mass on the first particle, offset at the top of its range
    send_item(16'hFFFF, 16'h0000, 1'b0);
    repeat (3) send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'h0000, 16'd13106, 1'b1);

    while (sent_count < 180) begin
      // keep the large sets away from the end so the count stays near the target
      kind = (sent_count > 110) ? $urandom_range(2, 19) : $urandom_range(0, 19);
      case (kind)
        0: send_set($urandom_range(60, 64), 1'b0, 1'b0);
        1: send_set($urandom_range(65, 70), 1'b0, 1'b0);
        2, 3: send_set($urandom_range(1, 10), 1'b1, 1'b1);
        4, 5: send_set($urandom_range(1, 12), 1'b0, 1'b1);
        default: send_set($urandom_range(1, 12), 1'b0, 1'b0);
      endcase
    end
    in_valid    <= 1'b0;
    last_weight <= 1'b0;

    // sample after the checker has taken the final transaction
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/sres_pkg.sv
design/sres_ram.sv
design/sres_seq.sv
design/sres_dp.sv
design/systematic_resampler_top.sv
bench/resampler_checker.sv
bench/tb.sv
